### rtl/core/rcpa_pkg.sv
`timescale 1ns / 1ps

package rcpa_pkg;

    // fixed field widths of the request and response
    localparam int OP_W      = 3;
    localparam int PAGE_W    = 10;
    localparam int CNT_OUT_W = 8;
    localparam int ST_W      = 3;

    // base page after reset
    localparam logic [PAGE_W-1:0] BASE_RESET = 10'd64;

    typedef enum logic [OP_W-1:0] {
        OP_INIT  = 3'd0,
        OP_ALLOC = 3'd1,
        OP_FREE  = 3'd2,
        OP_INC   = 3'd3,
        OP_DEC   = 3'd4,
        OP_GET   = 3'd5
    } opcode_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 3'd0,
        ST_RANGE = 3'd1,
        ST_ZERO  = 3'd2,
        ST_EMPTY = 3'd3,
        ST_SAT   = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_INIT,
        S_EXEC
    } state_t;

endpackage

### rtl/core/rcpa_if.sv
`timescale 1ns / 1ps

interface rcpa_req_if;
    import rcpa_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   opcode;
    logic [PAGE_W-1:0] page_number;

    modport source (output valid, output opcode, output page_number, input ready);
    modport sink   (input valid, input opcode, input page_number, output ready);
endinterface

interface rcpa_rsp_if;
    import rcpa_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [PAGE_W-1:0]    granted_page;
    logic                 granted;
    logic [CNT_OUT_W-1:0] count;
    logic [ST_W-1:0]      status;

    modport source (output valid, output granted_page, output granted, output count,
                    output status, input ready);
    modport sink   (input valid, input granted_page, input granted, input count,
                    input status, output ready);
endinterface

### rtl/core/refcounted_page_allocator_top.sv
`timescale 1ns / 1ps

// channel  dir  handshake     payload
// req      in   valid/ready   opcode, page_number
// rsp      out  valid/ready   granted_page, granted, count, status
// cfg      in   cfg_we        cfg_wdata (base_page)
//
// each request is a read-modify-write: accepting it reads the count and stack
// memories, then S_EXEC modifies and writes back through their single write ports.
// init sweeps every page through those write ports in S_INIT, then ends in S_EXEC.
// after reset a clearing pass over every page zeroes all counts, req.ready low.
// a response held by rsp.ready low stalls the next request in S_EXEC.
module refcounted_page_allocator_top #(
    parameter int NUM_PAGES  = 1024,
    parameter int COUNT_BITS = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [rcpa_pkg::PAGE_W-1:0] cfg_wdata,
    rcpa_req_if.sink                    req,
    rcpa_rsp_if.source                  rsp
);
    import rcpa_pkg::*;

    localparam int PW   = $clog2(NUM_PAGES);
    localparam int DW   = $clog2(NUM_PAGES + 1);
    localparam int CMPW = ((PW > PAGE_W) ? PW : PAGE_W) + 1;
    localparam int CXW  = (COUNT_BITS > CNT_OUT_W) ? COUNT_BITS : CNT_OUT_W;

    localparam logic [CMPW-1:0]       NP_W       = CMPW'(NUM_PAGES);
    localparam logic [PW-1:0]         LAST_PAGE  = PW'(NUM_PAGES - 1);
    localparam logic [DW-1:0]         DEPTH_FULL = DW'(NUM_PAGES);
    localparam logic [COUNT_BITS-1:0] CNT_MAX    = '1;
    localparam logic [COUNT_BITS-1:0] CNT_ONE    = COUNT_BITS'(1);

    // state and configuration
    state_t            state_reg, state_next;
    logic [PAGE_W-1:0] base_reg;
    logic [PW-1:0]     sweep_reg, sweep_next;
    logic [DW-1:0]     depth_reg, depth_next;

    // captured request and memory read data
    logic [OP_W-1:0]       op_reg;
    logic [PW-1:0]         pg_reg;
    logic                  inrange_reg;
    logic [COUNT_BITS-1:0] cnt_rd_reg;
    logic [PW-1:0]         stk_rd_reg;

    // memories
    logic [COUNT_BITS-1:0] cnt_mem [NUM_PAGES];
    logic [PW-1:0]         stk_mem [NUM_PAGES];

    logic                  cnt_we;
    logic [PW-1:0]         cnt_waddr;
    logic [COUNT_BITS-1:0] cnt_wdata;
    logic                  stk_we;
    logic [PW-1:0]         stk_waddr;
    logic [PW-1:0]         stk_wdata;

    // output register
    logic                 out_valid_reg, out_valid_next;
    logic [PAGE_W-1:0]    out_gpage_reg;
    logic                 out_granted_reg;
    logic [CNT_OUT_W-1:0] out_count_reg;
    logic [ST_W-1:0]      out_status_reg;

    // combinational helpers
    logic            req_fire;
    logic            exec_go;
    logic            sweep_last;
    logic            sweeping;
    logic [CMPW-1:0] pg_wide;
    logic [CMPW-1:0] base_wide;
    logic [CMPW-1:0] sweep_wide;
    logic [CMPW-1:0] fill_off;
    logic [CMPW-1:0] init_depth_w;
    logic [CMPW-1:0] gpage_ext;
    logic [PW-1:0]   pg_idx;
    logic            pg_inrange;
    logic            sweep_fill;
    logic [DW-1:0]   depth_dec;
    logic [PW-1:0]   top_idx;

    logic [COUNT_BITS-1:0] cnt_new;
    logic [CXW-1:0]        cnt_ext;
    logic                  cnt_upd;
    logic                  push_v;
    logic                  pop_v;
    logic                  granted_v;
    status_t               st_v;

    // handshake and address arithmetic
    assign req_fire     = req.valid && req.ready;
    assign exec_go      = (state_reg == S_EXEC) && (!out_valid_reg || rsp.ready);
    assign sweeping     = (state_reg == S_CLEAR) || (state_reg == S_INIT);
    assign sweep_last   = (sweep_reg == LAST_PAGE);
    assign pg_wide      = CMPW'(req.page_number);
    assign base_wide    = CMPW'(base_reg);
    assign sweep_wide   = CMPW'(sweep_reg);
    assign pg_idx       = pg_wide[PW-1:0];
    assign pg_inrange   = (pg_wide >= base_wide) && (pg_wide < NP_W);
    assign sweep_fill   = (sweep_wide >= base_wide);
    assign fill_off     = sweep_wide - base_wide;
    assign init_depth_w = (base_wide < NP_W) ? (NP_W - base_wide) : '0;
    assign depth_dec    = depth_reg - 1'b1;
    assign top_idx      = depth_dec[PW-1:0];
    assign sweep_next   = sweep_last ? '0 : sweep_reg + 1'b1;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (sweep_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (req_fire)
                    state_next = (req.opcode == OP_INIT) ? S_INIT : S_EXEC;
            end
            S_INIT:
            begin
                if (sweep_last)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (exec_go)
                    state_next = S_IDLE;
            end
            default: state_next = S_CLEAR;
        endcase
    end

    // state machine outputs
    always_comb
    begin
        req.ready = (state_reg == S_IDLE);
    end

    // modify step of the read-modify-write
    always_comb
    begin
        st_v      = ST_OK;
        granted_v = 1'b0;
        cnt_new   = '0;
        cnt_upd   = 1'b0;
        push_v    = 1'b0;
        pop_v     = 1'b0;
        unique case (op_reg) inside
            OP_ALLOC:
            begin
                if (depth_reg == '0)
                    st_v = ST_EMPTY;
                else
                begin
                    pop_v     = 1'b1;
                    granted_v = 1'b1;
                    cnt_new   = CNT_ONE;
                    cnt_upd   = 1'b1;
                end
            end
            OP_FREE, OP_INC, OP_DEC, OP_GET:
            begin
                if (!inrange_reg)
                    st_v = ST_RANGE;
                else
                begin
                    cnt_new = cnt_rd_reg;
                    case (op_reg)
                        OP_FREE:
                        begin
                            if (cnt_rd_reg == '0)
                                st_v = ST_ZERO;
                            else
                            begin
                                cnt_new = cnt_rd_reg - 1'b1;
                                cnt_upd = 1'b1;
                                push_v  = (cnt_new == '0) && (depth_reg != DEPTH_FULL);
                            end
                        end
                        OP_INC:
                        begin
                            if (cnt_rd_reg == CNT_MAX)
                                st_v = ST_SAT;
                            else
                            begin
                                cnt_new = cnt_rd_reg + 1'b1;
                                cnt_upd = 1'b1;
                            end
                        end
                        OP_DEC:
                        begin
                            if (cnt_rd_reg == '0)
                                st_v = ST_SAT;
                            else
                            begin
                                cnt_new = cnt_rd_reg - 1'b1;
                                cnt_upd = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            // init and unused codes report all zero
            default:
            begin
            end
        endcase
    end

    assign cnt_ext   = CXW'(cnt_new);
    assign gpage_ext = CMPW'(stk_rd_reg);

    // memory write ports: sweep during clear and init, else write back
    always_comb
    begin
        if (sweeping)
        begin
            cnt_we    = 1'b1;
            cnt_waddr = sweep_reg;
            cnt_wdata = '0;
            stk_we    = (state_reg == S_INIT) && sweep_fill;
            stk_waddr = fill_off[PW-1:0];
            stk_wdata = sweep_reg;
        end
        else
        begin
            cnt_we    = exec_go && cnt_upd;
            cnt_waddr = pop_v ? stk_rd_reg : pg_reg;
            cnt_wdata = cnt_new;
            stk_we    = exec_go && push_v;
            stk_waddr = depth_reg[PW-1:0];
            stk_wdata = pg_reg;
        end
    end

    // stack depth
    always_comb
    begin
        depth_next = depth_reg;
        if (exec_go)
        begin
            if (op_reg == OP_INIT)
                depth_next = init_depth_w[DW-1:0];
            else if (pop_v)
                depth_next = depth_dec;
            else if (push_v)
                depth_next = depth_reg + 1'b1;
        end
    end

    // output valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (exec_go)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            base_reg      <= BASE_RESET;
            sweep_reg     <= '0;
            depth_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                base_reg <= cfg_wdata;
            if (sweeping)
                sweep_reg <= sweep_next;
        end
    end

    // captured request
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            op_reg      <= req.opcode;
            pg_reg      <= pg_idx;
            inrange_reg <= pg_inrange;
        end
    end

    // count memory
    always_ff @(posedge clk)
    begin
        if (cnt_we)
            cnt_mem[cnt_waddr] <= cnt_wdata;
        if (req_fire)
            cnt_rd_reg <= cnt_mem[pg_idx];
    end

    // free stack memory
    always_ff @(posedge clk)
    begin
        if (stk_we)
            stk_mem[stk_waddr] <= stk_wdata;
        if (req_fire)
            stk_rd_reg <= stk_mem[top_idx];
    end

    // response payload
    always_ff @(posedge clk)
    begin
        if (exec_go)
        begin
            out_gpage_reg   <= granted_v ? gpage_ext[PAGE_W-1:0] : '0;
            out_granted_reg <= granted_v;
            out_count_reg   <= cnt_ext[CNT_OUT_W-1:0];
            out_status_reg  <= st_v;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.granted_page = out_gpage_reg;
    assign rsp.granted      = out_granted_reg;
    assign rsp.count        = out_count_reg;
    assign rsp.status       = out_status_reg;

endmodule

### rtl/core/rcpa_checker.sv
`timescale 1ns / 1ps

module rcpa_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           req_valid,
    input logic                           req_ready,
    input logic                           rsp_valid,
    input logic                           rsp_ready,
    input logic [rcpa_pkg::PAGE_W-1:0]    rsp_granted_page,
    input logic                           rsp_granted,
    input logic [rcpa_pkg::CNT_OUT_W-1:0] rsp_count,
    input logic [rcpa_pkg::ST_W-1:0]      rsp_status
);
    import rcpa_pkg::*;

    // one request in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request accepted back to back");

    // a granted page starts with one reference
    a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_granted) |-> (rsp_status == ST_OK && rsp_count == 8'd1))
        else $error("grant without ok status or count one");

    // no page number without a grant
    a_no_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_granted) |-> (rsp_granted_page == '0))
        else $error("page number reported without grant");

    // error codes other than saturation carry a zero count
    a_err_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp_status == ST_RANGE || rsp_status == ST_ZERO ||
                       rsp_status == ST_EMPTY)) |-> (rsp_count == '0))
        else $error("nonzero count with error status");

    // stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_granted_page) &&
            $stable(rsp_granted) && $stable(rsp_count) && $stable(rsp_status)))
        else $error("stalled response changed");

endmodule

bind refcounted_page_allocator_top rcpa_checker u_rcpa_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_granted_page (rsp.granted_page),
    .rsp_granted      (rsp.granted),
    .rsp_count        (rsp.count),
    .rsp_status       (rsp.status)
);
